FILE: src/cbm_pkg.sv
// Shared types, codes and helpers for the cartridge bank mapper.
`timescale 1ns / 1ps

package cbm_pkg;

  localparam int unsigned NumChrRegs = 8;
  localparam int unsigned ChrSelW    = $clog2(NumChrRegs);

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_XLAT_CPU = 2'd1,
    OP_XLAT_PPU = 2'd2,
    OP_NOP      = 2'd3
  } op_e;

  // Register select, address bits 3:0 of a write
  localparam logic [3:0] SubPrgRam = 4'h8;
  localparam logic [3:0] SubPrgLow = 4'h9;
  localparam logic [3:0] SubPrgMid = 4'hA;
  localparam logic [3:0] SubMirror = 4'hC;

  // Write windows, address bits 15:12
  localparam logic [3:0] WinWriteA = 4'hA;
  localparam logic [3:0] WinWriteC = 4'hC;

  // CPU 8 KB windows, address bits 15:13
  localparam logic [2:0] Win6000 = 3'd3;
  localparam logic [2:0] Win8000 = 3'd4;
  localparam logic [2:0] WinA000 = 3'd5;
  localparam logic [2:0] WinC000 = 3'd6;

  localparam logic [7:0] FixedPenult = 8'hFE;
  localparam logic [7:0] FixedLast   = 8'hFF;
  localparam logic [7:0] WramCode    = 8'h01;

  typedef struct packed {
    logic [NumChrRegs-1:0][7:0] chr;
    logic [7:0]                 prg_low;
    logic [7:0]                 prg_mid;
    logic [7:0]                 prg_ram;
    logic [1:0]                 mirror;
    logic                       game_sel;
  } map_state_t;

  typedef struct packed {
    logic       mapped;
    logic [5:0] prg_bank;
    logic       use_wram;
    logic [8:0] chr_bank;
    logic [1:0] mirroring;
  } result_t;

  // 8 KB bank: (reg & {gs,4'hF}) + gs*16
  function automatic logic [5:0] prog_window(logic [7:0] bank, logic gs);
    logic [4:0] masked;
    masked = bank[4:0] & {gs, 4'hF};
    return {1'b0, masked} + {1'b0, gs, 4'b0000};
  endfunction

endpackage

FILE: src/cartridge_bank_mapper_unit.sv
// Top level of the cartridge bank mapper: register file, translation and output buffer.
`timescale 1ns / 1ps
//
// Usage
//   Input channel: in_valid_i / in_stall_o carry one word per accepted edge:
//   opcode_i (0 CPU write, 1 CPU translate, 2 picture translate, 3 no-op),
//   cpu_addr_i, write_data_i and ppu_addr_i.
//   Output channel: out_valid_o / out_stall_i return exactly one result
//   word per input word, in order: mapped, bank numbers and current mirroring.
//   An accepted word shows on out_valid_o in the cycle after accept when the output is free.
//   Throughput: one word per cycle while in_stall_o is low. The translation is a single pass from
//   the input ports and bank registers into the result register; writes
//   update the bank registers at the accepting edge, so the next word
//   already sees them.
//   Stall: a two-entry output buffer (result register plus skid register)
//   lets one more word in while a result waits. in_stall_o rises only when
//   both entries hold results, and it is driven from a register.
//   Reset (rst_ni low, async): picture bank i holds i, program banks hold
//   0/1/0, mirroring and game select clear, and both buffer entries empty.
//

module cartridge_bank_mapper_unit
  import cbm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] cpu_addr_i,
  input  logic [7:0]  write_data_i,
  input  logic [12:0] ppu_addr_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        mapped_o,
  output logic [5:0]  prg_bank_o,
  output logic        use_work_ram_o,
  output logic [8:0]  chr_bank_o,
  output logic [1:0]  mirroring_o
);

  op_e        op;
  logic       in_take;
  logic       out_take;
  map_state_t bank_state;
  logic [1:0] mirror_next;
  result_t    res_new;

  result_t    out_q;
  result_t    skid_q;
  logic       out_valid_q;
  logic       skid_valid_q;

  assign op       = op_e'(opcode_i);
  assign in_take  = in_valid_i && !skid_valid_q;
  assign out_take = out_valid_q && !out_stall_i;

  cbm_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (in_take && (op == OP_WRITE)),
    .wr_addr_i    (cpu_addr_i),
    .wr_data_i    (write_data_i),
    .state_o      (bank_state),
    .mirror_next_o(mirror_next)
  );

  // Mirroring reflects a write carried by this same word
  cbm_xlate u_xlate (
    .opcode_i  (op),
    .cpu_addr_i(cpu_addr_i),
    .ppu_addr_i(ppu_addr_i),
    .state_i   (bank_state),
    .mirror_i  (mirror_next),
    .result_o  (res_new)
  );

  // Output buffer control: skid drains into the result register first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_take) begin
        out_valid_q  <= skid_valid_q || in_take;
        skid_valid_q <= 1'b0;
      end else if (in_take) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_take) begin
        out_q <= res_new;
      end
    end else if (in_take) begin
      skid_q <= res_new;
    end
  end

  assign in_stall_o     = skid_valid_q;
  assign out_valid_o    = out_valid_q;
  assign mapped_o       = out_q.mapped;
  assign prg_bank_o     = out_q.prg_bank;
  assign use_work_ram_o = out_q.use_wram;
  assign chr_bank_o     = out_q.chr_bank;
  assign mirroring_o    = out_q.mirroring;

  // Skid entry is only ever occupied behind a full result register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty result register");

  // A taken result always leaves the skid entry empty
  a_take_drains_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take |=> !skid_valid_q)
    else $error("skid entry still full after result taken");

  // A word accepted into an empty buffer shows up next cycle
  a_accept_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && !out_valid_q) |=> out_valid_q)
    else $error("accepted word did not reach the result register");

  // Work RAM hits are mapped and carry no ROM bank
  a_wram_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && use_work_ram_o) |-> (mapped_o && (prg_bank_o == 6'd0)))
    else $error("work RAM result with ROM bank or unmapped");

endmodule

FILE: src/cbm_regs.sv
// Bank register file with CPU write decode.
`timescale 1ns / 1ps

module cbm_regs
  import cbm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_en_i,
  input  logic [15:0] wr_addr_i,
  input  logic [7:0] wr_data_i,
  output map_state_t state_o,
  output logic [1:0] mirror_next_o
);

  map_state_t state_q, state_d;
  logic       hit;

  always_comb begin
    state_d = state_q;
    hit     = (wr_addr_i[15:12] == WinWriteA) || (wr_addr_i[15:12] == WinWriteC);
    if (wr_en_i && hit) begin
      if (!wr_addr_i[3]) begin
        state_d.chr[wr_addr_i[ChrSelW-1:0]] = wr_data_i;
      end else begin
        case (wr_addr_i[3:0])
          SubPrgRam: state_d.prg_ram = wr_data_i;
          SubPrgLow: state_d.prg_low = wr_data_i;
          SubPrgMid: state_d.prg_mid = wr_data_i;
          SubMirror: state_d.mirror  = wr_data_i[1:0];
          default:   ;
        endcase
      end
      state_d.game_sel = wr_addr_i[14];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChrRegs; i++) begin
        state_q.chr[i] <= 8'(i);
      end
      state_q.prg_low  <= 8'd0;
      state_q.prg_mid  <= 8'd1;
      state_q.prg_ram  <= 8'd0;
      state_q.mirror   <= 2'd0;
      state_q.game_sel <= 1'b0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o       = state_q;
  assign mirror_next_o = state_d.mirror;

endmodule

FILE: src/cbm_xlate.sv
// Address translation for CPU and picture bus lookups.
`timescale 1ns / 1ps

module cbm_xlate
  import cbm_pkg::*;
(
  input  op_e        opcode_i,
  input  logic [15:0] cpu_addr_i,
  input  logic [12:0] ppu_addr_i,
  input  map_state_t state_i,
  input  logic [1:0] mirror_i,
  output result_t    result_o
);

  logic [7:0] prg_src;

  always_comb begin
    case (cpu_addr_i[15:13])
      Win6000: prg_src = state_i.prg_ram;
      Win8000: prg_src = state_i.prg_low;
      WinA000: prg_src = state_i.prg_mid;
      WinC000: prg_src = FixedPenult;
      default: prg_src = FixedLast;
    endcase
  end

  always_comb begin
    result_o           = '0;
    result_o.mirroring = mirror_i;
    case (opcode_i)
      OP_XLAT_CPU: begin
        if (cpu_addr_i[15:13] >= Win6000) begin
          result_o.mapped = 1'b1;
          if (cpu_addr_i[15:13] == Win6000 && state_i.prg_ram == WramCode) begin
            result_o.use_wram = 1'b1;
          end else begin
            result_o.prg_bank = prog_window(prg_src, state_i.game_sel);
          end
        end
      end
      OP_XLAT_PPU: begin
        result_o.mapped   = 1'b1;
        result_o.chr_bank = {1'b0, state_i.chr[ppu_addr_i[12:10]]}
                          + {state_i.game_sel, 8'h00};
      end
      default: ;
    endcase
  end

endmodule

FILE: test/cbm_bank_checker.sv
// Checker for the cartridge bank mapper: watches both channels, predicts and compares results.
`timescale 1ns / 1ps

module cbm_bank_checker
  import cbm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] cpu_addr_i,
  input  logic [7:0]  write_data_i,
  input  logic [12:0] ppu_addr_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        mapped_i,
  input  logic [5:0]  prg_bank_i,
  input  logic        use_work_ram_i,
  input  logic [8:0]  chr_bank_i,
  input  logic [1:0]  mirroring_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // Mirror of the mapper's bank registers
  logic [7:0] chr_bank_q [NumChrRegs];
  logic [7:0] prg_low_q;
  logic [7:0] prg_mid_q;
  logic [7:0] prg_ram_q;
  logic [1:0] mirror_q;
  logic       game_sel_q;

  result_t     awaited_results [$];
  result_t     seen_word;
  result_t     want_word;
  result_t     next_word;
  int unsigned mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Game 1 widens the bank mask to 5 bits and moves up by 16 banks
  function automatic logic [5:0] bank_8k(input logic [7:0] bank_val, input logic gs);
    logic [7:0] lim;
    logic [7:0] sum;
    lim = gs ? 8'h1F : 8'h0F;
    sum = (bank_val & lim) + (gs ? 8'd16 : 8'd0);
    return sum[5:0];
  endfunction

  task automatic apply_word(input op_e op, input logic [15:0] addr, input logic [7:0] data,
                            input logic [12:0] paddr, output result_t res);
    res = '0;
    case (op)
      OP_WRITE: begin
        if (addr[15:12] == WinWriteA || addr[15:12] == WinWriteC) begin
          if (!addr[3]) begin
            chr_bank_q[addr[2:0]] = data;
          end else begin
            case (addr[3:0])
              SubPrgRam: prg_ram_q = data;
              SubPrgLow: prg_low_q = data;
              SubPrgMid: prg_mid_q = data;
              SubMirror: mirror_q  = data[1:0];
              default: ;
            endcase
          end
          game_sel_q = addr[14];
        end
      end
      OP_XLAT_CPU: begin
        res.mapped = (addr[15:13] >= Win6000);
        case (addr[15:13])
          Win6000: begin
            if (prg_ram_q == WramCode) res.use_wram = 1'b1;
            else res.prg_bank = bank_8k(prg_ram_q, game_sel_q);
          end
          Win8000: res.prg_bank = bank_8k(prg_low_q, game_sel_q);
          WinA000: res.prg_bank = bank_8k(prg_mid_q, game_sel_q);
          WinC000: res.prg_bank = bank_8k(FixedPenult, game_sel_q);
          default: begin
            if (res.mapped) res.prg_bank = bank_8k(FixedLast, game_sel_q);
          end
        endcase
      end
      OP_XLAT_PPU: begin
        res.mapped   = 1'b1;
        res.chr_bank = {1'b0, chr_bank_q[paddr[12:10]]} + {game_sel_q, 8'h00};
      end
      default: ;
    endcase
    res.mirroring = mirror_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChrRegs; i++) chr_bank_q[i] = 8'(i);
      prg_low_q  = 8'd0;
      prg_mid_q  = 8'd1;
      prg_ram_q  = 8'd0;
      mirror_q   = 2'd0;
      game_sel_q = 1'b0;
      awaited_results.delete();
      pending_o <= 0;
    end else begin
      // Output first: a word leaving now was accepted at an earlier edge
      if (out_valid_i && !out_stall_i) begin
        seen_word.mapped    = mapped_i;
        seen_word.prg_bank  = prg_bank_i;
        seen_word.use_wram  = use_work_ram_i;
        seen_word.chr_bank  = chr_bank_i;
        seen_word.mirroring = mirroring_i;
        if (awaited_results.size() == 0) begin
          report_mismatch("unrequested result word", int'(seen_word), 0);
        end else begin
          want_word = awaited_results.pop_front();
          if (seen_word.mapped != want_word.mapped)
            report_mismatch("mapped", int'(seen_word.mapped), int'(want_word.mapped));
          if (seen_word.prg_bank != want_word.prg_bank)
            report_mismatch("prg_bank", int'(seen_word.prg_bank), int'(want_word.prg_bank));
          if (seen_word.use_wram != want_word.use_wram)
            report_mismatch("use_work_ram", int'(seen_word.use_wram),
                            int'(want_word.use_wram));
          if (seen_word.chr_bank != want_word.chr_bank)
            report_mismatch("chr_bank", int'(seen_word.chr_bank), int'(want_word.chr_bank));
          if (seen_word.mirroring != want_word.mirroring)
            report_mismatch("mirroring", int'(seen_word.mirroring),
                            int'(want_word.mirroring));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        apply_word(op_e'(opcode_i), cpu_addr_i, write_data_i, ppu_addr_i, next_word);
        awaited_results.push_back(next_word);
      end
      pending_o <= awaited_results.size();
    end
  end

endmodule

FILE: test/cartridge_bank_mapper_unit_tb.sv
// Testbench top for the cartridge bank mapper: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module cartridge_bank_mapper_unit_tb;
  import cbm_pkg::*;

  // Random phase length, counted in words that produce a real effect
  localparam int unsigned RandomWords = 800;
  // Final stretch runs with no gaps and no stalls
  localparam int unsigned CalmWords   = 150;
  // Upper bound on the whole run; leave a wide margin over the slowest run
  localparam int unsigned CycleLimit  = 200000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  opcode;
  logic [15:0] cpu_addr;
  logic [7:0]  write_data;
  logic [12:0] ppu_addr;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        mapped;
  logic [5:0]  prg_bank;
  logic        use_work_ram;
  logic [8:0]  chr_bank;
  logic [1:0]  mirroring;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  logic        bursty = 1'b1;   // gaps and stalls allowed

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  cartridge_bank_mapper_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .opcode_i       (opcode),
    .cpu_addr_i     (cpu_addr),
    .write_data_i   (write_data),
    .ppu_addr_i     (ppu_addr),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .mapped_o       (mapped),
    .prg_bank_o     (prg_bank),
    .use_work_ram_o (use_work_ram),
    .chr_bank_o     (chr_bank),
    .mirroring_o    (mirroring)
  );

  cbm_bank_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .opcode_i       (opcode),
    .cpu_addr_i     (cpu_addr),
    .write_data_i   (write_data),
    .ppu_addr_i     (ppu_addr),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .mapped_i       (mapped),
    .prg_bank_i     (prg_bank),
    .use_work_ram_i (use_work_ram),
    .chr_bank_i     (chr_bank),
    .mirroring_i    (mirroring),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Watchdog: a hang or a lost result ends up here
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side back-pressure: random stall bursts.
  // One NBA to out_stall per edge, whichever branch is taken.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (bursty && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_stall  <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // Present one word and hold it until accepted. A gap, when taken, drops
  // valid first; back-to-back words keep valid high with no toggle.
  task automatic send_word(input op_e op, input logic [15:0] addr, input logic [7:0] data,
                           input logic [12:0] paddr);
    if (bursty && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    cpu_addr   <= addr;
    write_data <= data;
    ppu_addr   <= paddr;
    // in_stall is read before this edge's updates land, so this matches
    // what the block saw when it sampled valid
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // One random word. Most writes hit the register windows so the bank
  // registers really move; the rest land anywhere and get dropped.
  // Returns 0 for a dropped write, which does not count toward the total.
  task automatic send_random_word(output bit counted);
    op_e         op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [12:0] paddr;
    int unsigned pick;
    pick  = $urandom_range(0, 99);
    addr  = 16'($urandom);
    data  = 8'($urandom);
    paddr = 13'($urandom);
    if (pick < 35) begin
      op = OP_WRITE;
      if ($urandom_range(0, 9) != 0) begin
        addr[15:12] = $urandom_range(0, 1) ? WinWriteA : WinWriteC;
        // the work RAM code is a single value; aim at it on purpose
        if (addr[3:0] == SubPrgRam && $urandom_range(0, 2) == 0) data = WramCode;
      end
    end else if (pick < 70) begin
      op = OP_XLAT_CPU;
    end else if (pick < 90) begin
      op = OP_XLAT_PPU;
    end else begin
      op = OP_NOP;
    end
    counted = !(op == OP_WRITE && addr[15:12] != WinWriteA && addr[15:12] != WinWriteC);
    send_word(op, addr, data, paddr);
  endtask

  initial begin
    int unsigned done_words;
    bit          counted;
    done_words = 0;
    rst_ni     = 1'b0;
    in_valid   <= 1'b0;
    opcode     <= OP_NOP;
    cpu_addr   <= '0;
    write_data <= '0;
    ppu_addr   <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every window at reset values, ranges edges, then each register
    send_word(OP_XLAT_CPU, 16'h5FFF, 8'h00, 13'h0000);   // just below 0x6000: unmapped
    send_word(OP_XLAT_CPU, 16'h6000, 8'h00, 13'h0000);
    send_word(OP_XLAT_CPU, 16'h8000, 8'h00, 13'h0000);
    send_word(OP_XLAT_CPU, 16'hBFFF, 8'h00, 13'h0000);
    send_word(OP_XLAT_CPU, 16'hC000, 8'h00, 13'h0000);
    send_word(OP_XLAT_CPU, 16'hFFFF, 8'hFF, 13'h1FFF);   // fixed last bank
    send_word(OP_XLAT_PPU, 16'h0000, 8'h00, 13'h0000);
    send_word(OP_XLAT_PPU, 16'hFFFF, 8'hFF, 13'h1FFF);
    send_word(OP_NOP,      16'hFFFF, 8'hFF, 13'h1FFF);   // no-op carries zeros
    send_word(OP_WRITE,    16'hB008, 8'h01, 13'h0000);   // outside both ranges: dropped
    send_word(OP_XLAT_CPU, 16'h6000, 8'h00, 13'h0000);
    send_word(OP_WRITE,    16'hC008, 8'h01, 13'h0000);   // work RAM code, game 1
    send_word(OP_XLAT_CPU, 16'h7FFF, 8'h00, 13'h0000);
    send_word(OP_WRITE,    16'hC00C, 8'hFF, 13'h0000);   // mirroring single upper
    send_word(OP_WRITE,    16'hA009, 8'hFF, 13'h0000);   // low bank, back to game 0
    send_word(OP_XLAT_CPU, 16'h9FFF, 8'h00, 13'h0000);
    send_word(OP_WRITE,    16'hC00A, 8'hFF, 13'h0000);   // mid bank, game 1 mask
    send_word(OP_XLAT_CPU, 16'hA000, 8'h00, 13'h0000);
    send_word(OP_WRITE,    16'hA007, 8'hFF, 13'h0000);   // top picture slot
    send_word(OP_XLAT_PPU, 16'h0000, 8'h00, 13'h1C00);
    send_word(OP_WRITE,    16'hC00B, 8'h55, 13'h0000);   // no register, still sets game
    send_word(OP_XLAT_PPU, 16'h0000, 8'h00, 13'h1FFF);   // 0xFF + 256 = 0x1FF, still fits in 9 bits
    send_word(OP_WRITE,    16'hAF0F, 8'h00, 13'h0000);

    // Random body; the tail runs at full rate on both sides
    while (done_words < RandomWords) begin
      if (done_words >= RandomWords - CalmWords) bursty = 1'b0;
      send_random_word(counted);
      if (counted) done_words++;
    end
    in_valid <= 1'b0;

    // Let the checker's count catch the last accept, then drain
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
